// ===== design/rlpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpl_pkg
// Shared types and constants of the rate-limited press logger.
// ----------------------------------------------------------------------------
package rlpl_pkg;

  localparam int NUM_BUTTONS        = 12;
  localparam int PRESSES_PER_BUTTON = 4;
  localparam int LOG_DEPTH          = NUM_BUTTONS * PRESSES_PER_BUTTON;

  localparam int ADDR_W = $clog2(LOG_DEPTH);
  localparam int CNT_W  = 6;
  localparam int SEEN_W = $clog2(PRESSES_PER_BUTTON + 1);

  localparam int FUNC_W   = 2;
  localparam int MASK_W   = 12;
  localparam int TIME_W   = 32;
  localparam int IDX_W    = 8;
  localparam int BTN_W    = 4;
  localparam int STN_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  localparam logic [TIME_W-1:0] HOLDOFF_RESET = 32'd1000;
  localparam logic [STN_W-1:0]  STATION_RESET = 8'd0;
  localparam logic [MASK_W-1:0] BTN_VALID     = MASK_W'((1 << NUM_BUTTONS) - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION = 1'd1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_ENTRY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_ENTRY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SCAN,
    ST_CNT,
    ST_ENT
  } state_t;

  typedef struct packed {
    logic [STN_W-1:0]  station;
    logic [BTN_W-1:0]  button;
    logic [TIME_W-1:0] stamp;
  } log_word_t;

  localparam int WORD_W = $bits(log_word_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    log_word_t         wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              load;
    kind_t             kind;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] stamp;
    logic [BTN_W-1:0]  button;
    logic [STN_W-1:0]  station;
  } reply_t;

endpackage

// ===== design/rate_limited_press_logger_unit.sv =====
// ----------------------------------------------------------------------------
// rate_limited_press_logger_unit
// Timestamped button-press log with per-button count and hold-off limits.
// ----------------------------------------------------------------------------
// A count or entry reply raises out_tvalid once the sequencer has entered its
// count or entry state and the reply is registered, or later while the result
// register is still occupied; an entry index beyond the log count gives no reply.
// A tick scans the log for each pressed button in turn; a drop ends that
// button's scan early. The scan reads one log entry a cycle through the single
// read port. Transactions are handled one at a time; reset empties the log at once.
module rate_limited_press_logger_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // button_mask, now, entry_index, zero pad
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // press_count, entry_time, entry_button,
                                  // entry_station, zero pad
  output logic        out_tuser,  // reply_kind
  input  logic                               cfg_we,
  input  logic [rlpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlpl_pkg::CFG_W-1:0]         cfg_data
);

  logic [rlpl_pkg::TIME_W-1:0] holdoff_r;
  logic [rlpl_pkg::STN_W-1:0]  station_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [49:0]                 out_data_r;
  logic                        out_user_r;
  logic                        out_free;

  rlpl_pkg::reply_t    reply;
  rlpl_pkg::ram_req_t  ram_req;
  rlpl_pkg::log_word_t ram_rdata;
  logic [rlpl_pkg::WORD_W-1:0] ram_rword;

  assign out_free = !out_vld_r || out_tready;

  rlpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_mask   (in_tdata[11:0]),
    .in_now    (in_tdata[43:12]),
    .in_idx    (in_tdata[51:44]),
    .holdoff   (holdoff_r),
    .station   (station_r),
    .out_free  (out_free),
    .reply     (reply),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  rlpl_log_ram #(
    .DATA_W (rlpl_pkg::WORD_W),
    .DEPTH  (rlpl_pkg::LOG_DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rword)
  );

  assign ram_rdata = rlpl_pkg::log_word_t'(ram_rword);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= rlpl_pkg::HOLDOFF_RESET;
      station_r <= rlpl_pkg::STATION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlpl_pkg::CFG_HOLDOFF: holdoff_r <= cfg_data;
        rlpl_pkg::CFG_STATION: station_r <= cfg_data[rlpl_pkg::STN_W-1:0];
      endcase
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (reply.load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (reply.load) begin
      out_data_r <= {reply.station, reply.button, reply.stamp, reply.count};
      out_user_r <= reply.kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_data_r};
  assign out_tuser  = out_user_r;

endmodule

// ===== design/rlpl_log_ram.sv =====
// ----------------------------------------------------------------------------
// rlpl_log_ram
// Simple dual-port log memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rlpl_log_ram #(
  parameter int DATA_W = 44,
  parameter int DEPTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rlpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlpl_ctrl
// Sequencer that scans the log memory for each pressed button, appends
// accepted presses, serves count and entry reads and clears the log.
// ----------------------------------------------------------------------------
module rlpl_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rlpl_pkg::FUNC_W-1:0]    in_func,
  input  logic [rlpl_pkg::MASK_W-1:0]    in_mask,
  input  logic [rlpl_pkg::TIME_W-1:0]    in_now,
  input  logic [rlpl_pkg::IDX_W-1:0]     in_idx,
  input  logic [rlpl_pkg::TIME_W-1:0]    holdoff,
  input  logic [rlpl_pkg::STN_W-1:0]     station,
  input  logic                           out_free,
  output rlpl_pkg::reply_t               reply,
  output rlpl_pkg::ram_req_t             ram_req,
  input  rlpl_pkg::log_word_t            ram_rdata
);

  rlpl_pkg::state_t state_r, state_nxt;

  logic [rlpl_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [rlpl_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic [rlpl_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [rlpl_pkg::BTN_W-1:0]  btn_r, btn_nxt;
  logic [rlpl_pkg::CNT_W-1:0]  rd_k_r, rd_k_nxt;
  logic                        pend_r, pend_nxt;
  logic [rlpl_pkg::SEEN_W-1:0] seen_r, seen_nxt;

  logic                        accept;
  logic                        issue;
  logic                        match;
  logic                        drop;
  logic                        scan_done;
  logic                        idx_ok;
  logic [rlpl_pkg::SEEN_W:0]   seen_inc;
  logic [rlpl_pkg::TIME_W-1:0] age;
  logic [rlpl_pkg::BTN_W-1:0]  first_btn;

  function automatic logic [rlpl_pkg::BTN_W-1:0] lowest_set(
    input logic [rlpl_pkg::MASK_W-1:0] m
  );
    logic [rlpl_pkg::BTN_W-1:0] r;
    r = '0;
    for (int i = rlpl_pkg::MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = rlpl_pkg::BTN_W'(i);
      end
    end
    return r;
  endfunction

  assign in_ready  = (state_r == rlpl_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_ok    = in_idx < rlpl_pkg::IDX_W'(count_r);
  assign first_btn = lowest_set(mask_r);

  assign issue     = (state_r == rlpl_pkg::ST_SCAN) && (rd_k_r < count_r);
  assign match     = pend_r && (ram_rdata.button == btn_r) && (ram_rdata.stamp != '0);
  assign seen_inc  = {1'b0, seen_r} + (rlpl_pkg::SEEN_W + 1)'(1);
  assign age       = now_r - ram_rdata.stamp;
  assign drop      = match && ((seen_inc >= (rlpl_pkg::SEEN_W + 1)'(rlpl_pkg::PRESSES_PER_BUTTON))
                               || (age < holdoff));
  assign scan_done = !issue && !pend_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlpl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rlpl_pkg::func_t'(in_func))
            rlpl_pkg::FUNC_TICK:  state_nxt = rlpl_pkg::ST_NEXT;
            rlpl_pkg::FUNC_COUNT: state_nxt = rlpl_pkg::ST_CNT;
            rlpl_pkg::FUNC_ENTRY: state_nxt = idx_ok ? rlpl_pkg::ST_ENT : rlpl_pkg::ST_IDLE;
            rlpl_pkg::FUNC_CLEAR: state_nxt = rlpl_pkg::ST_IDLE;
          endcase
        end
      end
      rlpl_pkg::ST_NEXT: begin
        state_nxt = (mask_r == '0) ? rlpl_pkg::ST_IDLE : rlpl_pkg::ST_SCAN;
      end
      rlpl_pkg::ST_SCAN: begin
        if (drop || scan_done) begin
          state_nxt = rlpl_pkg::ST_NEXT;
        end
      end
      rlpl_pkg::ST_CNT, rlpl_pkg::ST_ENT: begin
        if (out_free) begin
          state_nxt = rlpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rlpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    mask_nxt  = mask_r;
    now_nxt   = now_r;
    btn_nxt   = btn_r;
    rd_k_nxt  = rd_k_r;
    pend_nxt  = 1'b0;
    seen_nxt  = seen_r;

    ram_req       = '0;
    ram_req.waddr = count_r[rlpl_pkg::ADDR_W-1:0];
    ram_req.wdata = '{station: station, button: btn_r, stamp: now_r};
    ram_req.raddr = rd_k_r[rlpl_pkg::ADDR_W-1:0];

    reply         = '0;
    reply.count   = count_r;
    reply.kind    = rlpl_pkg::KIND_COUNT;

    unique case (state_r)
      rlpl_pkg::ST_IDLE: begin
        if (accept) begin
          mask_nxt = in_mask & rlpl_pkg::BTN_VALID;
          now_nxt  = in_now;
          if (rlpl_pkg::func_t'(in_func) == rlpl_pkg::FUNC_CLEAR) begin
            count_nxt = '0;
          end
          if ((rlpl_pkg::func_t'(in_func) == rlpl_pkg::FUNC_ENTRY) && idx_ok) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = in_idx[rlpl_pkg::ADDR_W-1:0];
          end
        end
      end
      rlpl_pkg::ST_NEXT: begin
        btn_nxt  = first_btn;
        mask_nxt = mask_r & ~(rlpl_pkg::MASK_W'(1) << first_btn);
        rd_k_nxt = '0;
        seen_nxt = '0;
      end
      rlpl_pkg::ST_SCAN: begin
        ram_req.re = issue;
        rd_k_nxt   = rd_k_r + rlpl_pkg::CNT_W'(issue);
        pend_nxt   = issue && !drop;
        if (match) begin
          seen_nxt = seen_inc[rlpl_pkg::SEEN_W-1:0];
        end
        if (scan_done && (count_r < rlpl_pkg::CNT_W'(rlpl_pkg::LOG_DEPTH))) begin
          ram_req.we = 1'b1;
          count_nxt  = count_r + rlpl_pkg::CNT_W'(1);
        end
      end
      rlpl_pkg::ST_CNT: begin
        reply.load = out_free;
      end
      rlpl_pkg::ST_ENT: begin
        reply.load    = out_free;
        reply.kind    = rlpl_pkg::KIND_ENTRY;
        reply.stamp   = ram_rdata.stamp;
        reply.button  = ram_rdata.button;
        reply.station = ram_rdata.station;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlpl_pkg::ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    now_r  <= now_nxt;
    btn_r  <= btn_nxt;
    rd_k_r <= rd_k_nxt;
    seen_r <= seen_nxt;
  end

endmodule
